// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SIU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion %m failed");

// Antecedent in one cycle implies consequent in the next one.
`define SIU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion %m failed");

`endif

// ----- hw/rtl/siu_pkg.sv -----
`timescale 1ns / 1ps

package siu_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int MAX_FACTOR_DEF  = 16;
    localparam int FACTOR_REG_W    = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 5;

    localparam logic [FACTOR_REG_W-1:0] FACTOR_RESET = FACTOR_REG_W'(4);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FACTOR = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_MODE   = t_cfg_idx'(1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_in;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          run_last;
        logic                          stream_end;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic save_older;
        logic quad;
        logic prep;
        logic mult;
        logic div_go;
        logic div_sel;
        logic take_d0;
        logic take_d2;
        logic load_pt;
        logic load_fin;
        logic run_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic out_space;
    } t_sts;

endpackage

// ----- hw/rtl/siu_div.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module siu_div #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic        [DEN_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quot,
    output logic        [DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_mag;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic             rem_zero;

    assign shifted  = {r_rem, r_mag[NUM_W-1]};
    assign diff     = shifted - {1'b0, r_den};
    assign ge       = shifted >= {1'b0, r_den};
    assign rem_zero = (r_rem == '0);

    // Restoring division of the magnitude, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_neg <= i_num[NUM_W-1];
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            r_mag <= {r_mag[NUM_W-2:0], ge};
        end
    end

    // Floor semantics: a negative dividend with a remainder rounds down.
    assign o_done = r_done;
    assign o_quot = r_neg ? (rem_zero ? -$signed(r_mag) : ~$signed(r_mag)) : $signed(r_mag);
    assign o_rem  = (r_neg && !rem_zero) ? (r_den - r_rem) : r_rem;

    `SIU_ASSERT(a_start_idle, i_clk, i_rst_n, i_start |-> !r_busy)
    `SIU_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done)

endmodule

// ----- hw/rtl/siu_dp.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module siu_dp #(
    parameter int MAX_FACTOR = siu_pkg::MAX_FACTOR_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  siu_pkg::t_in                           i_in_data,
    input  siu_pkg::t_cmd                          i_cmd,
    input  logic [$clog2(MAX_FACTOR + 1)-1:0]      i_n,
    output siu_pkg::t_sts                          o_sts,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output siu_pkg::t_out                          o_out_data
);

    import siu_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int FW = $clog2(MAX_FACTOR + 1);
    localparam int DW = $clog2(2 * MAX_FACTOR * MAX_FACTOR + 1);
    localparam int KW = S + 2;
    localparam int TW = S + 3;
    localparam int W  = S + FW + 4;

    logic signed [S-1:0]  r_older;
    logic signed [S-1:0]  r_prior;
    logic signed [S-1:0]  r_a;
    logic signed [S-1:0]  r_b;
    logic signed [S-1:0]  r_c;
    logic                 r_quad;
    logic        [DW-1:0] r_d;
    logic signed [KW-1:0] r_k2;
    logic signed [TW-1:0] r_t;
    logic signed [W-1:0]  r_d0n;
    logic signed [W-1:0]  r_d2n;
    logic signed [W-1:0]  r_nq;
    logic        [DW-1:0] r_nr;
    logic signed [W-1:0]  r_dq;
    logic        [DW-1:0] r_dr;
    logic signed [W-1:0]  r_eq;
    logic        [DW-1:0] r_er;
    t_out                 r_out;
    logic                 r_ovalid;

    logic        [2*FW-1:0] n_sq;
    logic        [2*FW:0]   d_quad;
    logic signed [KW-1:0]   b2;
    logic signed [KW-1:0]   k2;
    logic signed [TW-1:0]   a3;
    logic signed [TW-1:0]   b4;
    logic signed [TW-1:0]   t;
    logic signed [W-1:0]    prod;
    logic signed [W-1:0]    k2_w;
    logic signed [W-1:0]    k2_x2;
    logic signed [W-1:0]    lin_step;
    logic signed [W-1:0]    div_q;
    logic        [DW-1:0]   div_r;
    logic                   div_done;
    logic        [DW:0]     sum_n;
    logic                   carry_n;
    logic        [DW:0]     sum_d;
    logic                   carry_d;
    logic        [DW:0]     twice_r;
    logic                   round_up;
    logic signed [W-1:0]    rounded;
    logic        [W-S:0]    top_bits;
    logic signed [S-1:0]    sat;

    // Node spacing: d = factor for a line, 2 * factor^2 for the parabola.
    assign n_sq   = i_n * i_n;
    assign d_quad = {n_sq, 1'b0};

    assign b2 = KW'(r_b) <<< 1;
    assign k2 = KW'(r_a) - b2 + KW'(r_c);
    assign a3 = (TW'(r_a) <<< 1) + TW'(r_a);
    assign b4 = TW'(r_b) <<< 2;
    assign t  = b4 - a3 - TW'(r_c);

    assign prod     = $signed({1'b0, i_n}) * r_t;
    assign k2_w     = W'(r_k2);
    assign k2_x2    = k2_w <<< 1;
    assign lin_step = W'(r_c) - W'(r_a);

    siu_div #(
        .NUM_W (W),
        .DEN_W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (i_cmd.div_sel ? r_d2n : r_d0n),
        .i_den   (r_d),
        .o_done  (div_done),
        .o_quot  (div_q),
        .o_rem   (div_r)
    );

    // Numerator and first difference are held as quotient and remainder by d.
    assign sum_n   = {1'b0, r_nr} + {1'b0, r_dr};
    assign carry_n = sum_n >= {1'b0, r_d};
    assign sum_d   = {1'b0, r_dr} + {1'b0, r_er};
    assign carry_d = sum_d >= {1'b0, r_d};

    // Round to nearest; a tie goes up only for a non-negative quotient.
    assign twice_r  = {r_nr, 1'b0};
    assign round_up = (twice_r > {1'b0, r_d}) || ((twice_r == {1'b0, r_d}) && !r_nq[W-1]);
    assign rounded  = r_nq + W'(round_up);
    assign top_bits = rounded[W-1:S-1];

    always_comb begin
        if ((&top_bits) || !(|top_bits)) begin
            sat = rounded[S-1:0];
        end else if (rounded[W-1]) begin
            sat = {1'b1, {(S-1){1'b0}}};
        end else begin
            sat = {1'b0, {(S-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older <= '0;
            r_prior <= '0;
        end else if (i_cmd.capture) begin
            r_prior <= i_in_data.sample;
            if (i_cmd.save_older) begin
                r_older <= r_prior;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_a    <= i_cmd.quad ? r_older : r_prior;
            r_b    <= r_prior;
            r_c    <= i_in_data.sample;
            r_quad <= i_cmd.quad;
        end
        if (i_cmd.prep) begin
            r_d  <= r_quad ? DW'(d_quad) : DW'(i_n);
            r_k2 <= k2;
            r_t  <= t;
            r_nq <= W'(r_a);
            r_nr <= '0;
        end
        if (i_cmd.mult) begin
            r_d0n <= r_quad ? (k2_w + prod) : lin_step;
            r_d2n <= r_quad ? k2_x2 : '0;
        end
        if (i_cmd.take_d0) begin
            r_dq <= div_q;
            r_dr <= div_r;
        end
        if (i_cmd.take_d2) begin
            r_eq <= div_q;
            r_er <= div_r;
        end
        if (i_cmd.load_pt) begin
            r_nr <= carry_n ? DW'(sum_n - {1'b0, r_d}) : sum_n[DW-1:0];
            r_nq <= r_nq + r_dq + W'(carry_n);
            r_dr <= carry_d ? DW'(sum_d - {1'b0, r_d}) : sum_d[DW-1:0];
            r_dq <= r_dq + r_eq + W'(carry_d);
            r_out.value      <= sat;
            r_out.run_last   <= i_cmd.run_last;
            r_out.stream_end <= 1'b0;
        end else if (i_cmd.load_fin) begin
            r_out.value      <= r_c;
            r_out.run_last   <= 1'b1;
            r_out.stream_end <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_pt || i_cmd.load_fin) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_sts.div_done  = div_done;
    assign o_sts.out_space = !r_ovalid || !i_out_stall;
    assign o_out_valid     = r_ovalid;
    assign o_out_data      = r_out;

    `SIU_ASSERT(a_no_load_blocked, i_clk, i_rst_n,
        (r_ovalid && i_out_stall) |-> !(i_cmd.load_pt || i_cmd.load_fin))

endmodule

// ----- hw/rtl/siu_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module siu_ctrl #(
    parameter int MAX_FACTOR = siu_pkg::MAX_FACTOR_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  siu_pkg::t_cfg_idx                      i_cfg_index,
    input  logic [siu_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_last,
    output logic                                   o_in_stall,
    output siu_pkg::t_cmd                          o_cmd,
    output logic [$clog2(MAX_FACTOR + 1)-1:0]      o_n,
    input  siu_pkg::t_sts                          i_sts
);

    import siu_pkg::*;

    localparam int FW = $clog2(MAX_FACTOR + 1);
    localparam int CW = FW + 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PREP  = 9'b000000010,
        S_MULT  = 9'b000000100,
        S_GO0   = 9'b000001000,
        S_WAIT0 = 9'b000010000,
        S_GO1   = 9'b000100000,
        S_WAIT1 = 9'b001000000,
        S_EMIT  = 9'b010000000,
        S_FINAL = 9'b100000000
    } t_state;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic                    r_have, n_have;
    logic                    r_odd, n_odd;
    logic                    r_last, n_last;
    logic [FACTOR_REG_W-1:0] r_factor;
    logic                    r_mode;

    logic [FW-1:0]           n_fac;
    logic                    seg;
    logic                    quad;
    logic                    save;

    always_comb begin
        if (r_factor == '0) begin
            n_fac = FW'(1);
        end else if (r_factor > FACTOR_REG_W'(MAX_FACTOR)) begin
            n_fac = FW'(MAX_FACTOR);
        end else begin
            n_fac = FW'(r_factor);
        end
    end

    // The parabola needs a stored anchor and middle; otherwise a line is drawn.
    assign quad = r_have && r_mode && r_odd;
    assign seg  = r_have && (!r_mode || r_odd || i_in_last);
    assign save = r_have && r_mode && !r_odd && !i_in_last;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_cnt   = r_cnt;
        n_have  = r_have;
        n_odd   = r_odd;
        n_last  = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture    = 1'b1;
                    o_cmd.quad       = quad;
                    o_cmd.save_older = save;
                    n_last           = i_in_last;
                    n_cnt            = quad ? {n_fac, 1'b0} : CW'(n_fac);
                    n_have           = !i_in_last;
                    n_odd            = save;
                    if (seg) begin
                        n_state = S_PREP;
                    end else if (i_in_last) begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_MULT;
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_GO0;
            end
            S_GO0: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_WAIT0;
            end
            S_WAIT0: begin
                if (i_sts.div_done) begin
                    o_cmd.take_d0 = 1'b1;
                    n_state       = S_GO1;
                end
            end
            S_GO1: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = 1'b1;
                n_state       = S_WAIT1;
            end
            S_WAIT1: begin
                if (i_sts.div_done) begin
                    o_cmd.take_d2 = 1'b1;
                    n_state       = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_space) begin
                    o_cmd.load_pt  = 1'b1;
                    o_cmd.run_last = (r_cnt == CW'(1)) && !r_last;
                    n_cnt          = r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        n_state = r_last ? S_FINAL : S_IDLE;
                    end
                end
            end
            S_FINAL: begin
                if (i_sts.out_space) begin
                    o_cmd.load_fin = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_have  <= 1'b0;
            r_odd   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_have  <= n_have;
            r_odd   <= n_odd;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= FACTOR_RESET;
            r_mode   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FACTOR: r_factor <= i_cfg_data[FACTOR_REG_W-1:0];
                CFG_MODE:   r_mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_n         = n_fac;

    `SIU_ASSERT(a_emit_count, i_clk, i_rst_n, (r_state == S_EMIT) |-> (r_cnt != '0))

endmodule

// ----- hw/rtl/sample_upsampling_interpolator_core.sv -----
`timescale 1ns / 1ps
// Channel   Signals                                   Direction
// config    i_cfg_valid o_cfg_ready i_cfg_index/data  write, valid/ready
// input     i_in_valid o_in_stall i_in_data           in, valid/stall
// output    o_out_valid i_out_stall o_out_data        out, valid/stall
//
// A request that produces no point leaves the controller in S_IDLE; the block is ready the next cycle.
// A request with a segment passes S_PREP, S_MULT, S_GO0, S_WAIT0, S_GO1, S_WAIT1, S_EMIT;
// the bit-serial divider, W = SAMPLE_BITS + clog2(MAX_FACTOR + 1) + 4 (25 by default) wide,
// finds the step sizes twice per segment; points leave one per cycle unless output stalls.
// Reset is synchronous and active low; registers return to factor 4, linear mode.
// Output stall holds the result register and pauses the point sequence in place.

module sample_upsampling_interpolator_core #(
    parameter int MAX_FACTOR = siu_pkg::MAX_FACTOR_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  siu_pkg::t_cfg_idx              i_cfg_index,
    input  logic [siu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  siu_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output siu_pkg::t_out                  o_out_data
);

    import siu_pkg::*;

    localparam int FW = $clog2(MAX_FACTOR + 1);

    t_cmd          cmd;
    t_sts          sts;
    logic [FW-1:0] n_val;

    siu_ctrl #(
        .MAX_FACTOR (MAX_FACTOR)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.last_in),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd),
        .o_n         (n_val),
        .i_sts       (sts)
    );

    siu_dp #(
        .MAX_FACTOR (MAX_FACTOR)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_n         (n_val),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
